>>> hw/rtl/accel_shake_detector_top_defines.svh
// ----------------------------------------------------------------------------
// Shake detector assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ACCEL_SHAKE_DETECTOR_TOP_DEFINES_SVH
`define ACCEL_SHAKE_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ASD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/asd_pkg.sv
// ----------------------------------------------------------------------------
// Shake detector package
// Widths, codes, weights, reset values, beat layout, FSM state type, abs16.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int AXIS_W   = 16;
    localparam int SUMSQ_W  = 32;
    localparam int ROOT_W   = 16;
    localparam int SMOOTH_W = 24;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = 32;
    localparam int LIMIT_W  = 17;
    localparam int CALSUM_W = 22;
    localparam int CALCNT_W = 6;
    localparam int TIMER_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int REQ_W    = 2;

    localparam logic [REQ_W-1:0] REQ_DETECT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CAL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MARGIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOCKOUT = 1'b1;

    localparam logic [7:0] SMOOTH_OLD_WT = 8'd179;
    localparam logic [7:0] SMOOTH_NEW_WT = 8'd77;

    localparam logic [CFG_W-1:0]    MARGIN_RST  = 16'd8192;
    localparam logic [CFG_W-1:0]    LOCKOUT_RST = 16'd100;
    localparam logic [SMOOTH_W-1:0] SMOOTH_RST  = 24'h400000;
    localparam logic [ROOT_W-1:0]   REST_RST    = 16'd16384;
    localparam logic [TIMER_W-1:0]  TIMER_MAX   = 16'hFFFF;

    // input beat: tdata = x, y, z; tuser = req_type
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = REQ_W;
    localparam int X_LSB = 0;
    localparam int Y_LSB = 16;
    localparam int Z_LSB = 32;

    // result beat
    localparam int M_TDATA_W  = 56;
    localparam int SHAKE_BIT  = 0;
    localparam int MAG_LSB    = 1;
    localparam int SMOOTH_LSB = 17;
    localparam int BASE_LSB   = 33;
    localparam int DONE_BIT   = 49;
    localparam int M_PAD_W    = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_CALSUM,
        ST_DIVIDE,
        ST_SMOOTH,
        ST_BLEND,
        ST_JUDGE,
        ST_EMIT
    } asd_state_t;

    function automatic logic [AXIS_W-1:0] abs16(input logic [AXIS_W-1:0] v);
        abs16 = v[AXIS_W-1] ? (~v + 16'd1) : v;
    endfunction

endpackage

>>> hw/rtl/accel_shake_detector_top.sv
// ----------------------------------------------------------------------------
// Accelerometer shake detector
// s_ channel: one beat per request. tuser carries the request kind (detect
//   sample, millisecond tick, calibration sample), tdata the three signed
//   axes. m_ channel: exactly one result beat per request.
// cfg_ port: shake margin (index 0) and lockout in ms (index 1), written
//   while no request is in flight.
// Processing, acceptance to result valid:
//   tick or unused kind: goes straight to the emit step.
//   detect sample: bit-serial squaring, square root, then smoothing and
//   threshold steps.
//   calibration sample: squaring, square root and accumulation, plus a
//   serial divide for the mean when it closes a run.
// One request at a time; s_tready is high only while idle, so the next
//   beat is taken the cycle after the result is loaded into the output
//   register.
// Reset restores config defaults, smoother and base to 1 g, clears the
//   calibration run and ms timer, and drops m_tvalid. A stalled m_ side holds
//   the result; the next request is accepted and computed, then waits.
// ----------------------------------------------------------------------------
module accel_shake_detector_top import asd_pkg::*; #(
    parameter int CAL_SAMPLES = 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // accel_x, accel_y, accel_z
    input  logic [S_TUSER_W-1:0] s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // shake, magnitude, smoothed_level, base_level, calibration_done, pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    asd_state_t state_reg, state_next;

    logic [CFG_W-1:0]    margin_reg, margin_next;
    logic [CFG_W-1:0]    lockout_reg, lockout_next;
    logic [SMOOTH_W-1:0] smooth_reg, smooth_next;
    logic [ROOT_W-1:0]   rest_reg, rest_next;
    logic [CALSUM_W-1:0] cal_sum_reg, cal_sum_next;
    logic [CALCNT_W-1:0] cal_cnt_reg, cal_cnt_next;
    logic [TIMER_W-1:0]  ms_reg, ms_next;

    logic [REQ_W-1:0]    req_reg, req_next;
    logic [ROOT_W-1:0]   mag_reg, mag_next;
    logic                shake_reg, shake_next;
    logic                done_reg, done_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                sq_start, sq_done;
    logic [SUMSQ_W-1:0]  sq_sum;
    logic                rt_start, rt_done;
    logic [ROOT_W-1:0]   rt_root;
    logic                dv_start, dv_done;
    logic [CALSUM_W-1:0] dv_quot;

    logic                accept;
    logic [CALSUM_W-1:0] cal_sum_add;
    logic [CALCNT_W-1:0] cal_cnt_inc;
    logic [SMOOTH_W-1:0] blend;
    logic                over_limit;
    logic                slot_free;

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign cal_sum_add = cal_sum_reg + CALSUM_W'(mag_reg);
    assign cal_cnt_inc = cal_cnt_reg + 1'b1;
    assign blend       = prod_reg[PROD_W-1 -: SMOOTH_W]
                       + SMOOTH_W'(SMOOTH_W'(mag_reg) * SMOOTH_W'(SMOOTH_NEW_WT));
    assign over_limit  = {1'b0, smooth_reg} > {limit_reg, {FRAC_W{1'b0}}};
    assign slot_free   = !m_valid_reg || m_tready;

    asd_sumsq u_sumsq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .mag_x   (abs16(s_tdata[X_LSB +: AXIS_W])),
        .mag_y   (abs16(s_tdata[Y_LSB +: AXIS_W])),
        .mag_z   (abs16(s_tdata[Z_LSB +: AXIS_W])),
        .done    (sq_done),
        .sum     (sq_sum)
    );

    asd_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rt_start),
        .value   (sq_sum),
        .done    (rt_done),
        .root    (rt_root)
    );

    asd_div #(
        .DIVISOR (CAL_SAMPLES)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (cal_sum_add),
        .done     (dv_done),
        .quotient (dv_quot)
    );

    always_comb begin
        state_next   = state_reg;
        margin_next  = margin_reg;
        lockout_next = lockout_reg;
        smooth_next  = smooth_reg;
        rest_next    = rest_reg;
        cal_sum_next = cal_sum_reg;
        cal_cnt_next = cal_cnt_reg;
        ms_next      = ms_reg;
        req_next     = req_reg;
        mag_next     = mag_reg;
        shake_next   = shake_reg;
        done_next    = done_reg;
        prod_next    = prod_reg;
        limit_next   = limit_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        sq_start     = 1'b0;
        rt_start     = 1'b0;
        dv_start     = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDX_MARGIN:  margin_next  = cfg_wdata;
                CFG_IDX_LOCKOUT: lockout_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next   = s_tuser;
                    mag_next   = '0;
                    shake_next = 1'b0;
                    done_next  = 1'b0;
                    case (s_tuser)
                        REQ_DETECT, REQ_CAL: begin
                            sq_start   = 1'b1;
                            state_next = ST_SQUARE;
                        end
                        REQ_TICK: begin
                            if (ms_reg != TIMER_MAX) begin
                                ms_next = ms_reg + 1'b1;
                            end
                            state_next = ST_EMIT;
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SQUARE: begin
                if (sq_done) begin
                    rt_start   = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (rt_done) begin
                    mag_next   = rt_root;
                    state_next = (req_reg == REQ_CAL) ? ST_CALSUM : ST_SMOOTH;
                end
            end
            ST_CALSUM: begin
                cal_sum_next = cal_sum_add;
                cal_cnt_next = cal_cnt_inc;
                if (cal_cnt_inc >= CALCNT_W'(CAL_SAMPLES)) begin
                    dv_start   = 1'b1;
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIVIDE: begin
                if (dv_done) begin
                    rest_next    = dv_quot[ROOT_W-1:0];
                    cal_sum_next = '0;
                    cal_cnt_next = '0;
                    done_next    = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_SMOOTH: begin
                prod_next  = PROD_W'(smooth_reg) * PROD_W'(SMOOTH_OLD_WT);
                limit_next = LIMIT_W'(rest_reg) + LIMIT_W'(margin_reg);
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                smooth_next = blend;
                state_next  = ST_JUDGE;
            end
            ST_JUDGE: begin
                if (over_limit && (ms_reg > lockout_reg)) begin
                    shake_next = 1'b1;
                    ms_next    = '0;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, done_reg, rest_reg,
                                    smooth_reg[SMOOTH_W-1 -: ROOT_W], mag_reg, shake_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            margin_reg  <= MARGIN_RST;
            lockout_reg <= LOCKOUT_RST;
            smooth_reg  <= SMOOTH_RST;
            rest_reg    <= REST_RST;
            cal_sum_reg <= '0;
            cal_cnt_reg <= '0;
            ms_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            margin_reg  <= margin_next;
            lockout_reg <= lockout_next;
            smooth_reg  <= smooth_next;
            rest_reg    <= rest_next;
            cal_sum_reg <= cal_sum_next;
            cal_cnt_reg <= cal_cnt_next;
            ms_reg      <= ms_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        mag_reg    <= mag_next;
        shake_reg  <= shake_next;
        done_reg   <= done_next;
        prod_reg   <= prod_next;
        limit_reg  <= limit_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hw/rtl/asd_sumsq.sv
// ----------------------------------------------------------------------------
// Shake detector sum of squares
// Bit-serial shift-add squaring of three axes, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module asd_sumsq import asd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [AXIS_W-1:0]  mag_x,
    input  logic [AXIS_W-1:0]  mag_y,
    input  logic [AXIS_W-1:0]  mag_z,
    output logic               done,
    output logic [SUMSQ_W-1:0] sum
);

    localparam int STEP_W = $clog2(AXIS_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(AXIS_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [AXIS_W-1:0]   mx_reg, mx_next, my_reg, my_next, mz_reg, mz_next;
    logic [SUMSQ_W-1:0]  ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [SUMSQ_W-1:0]  acc_reg, acc_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        mz_next   = mz_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        az_next   = az_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            mx_next   = mag_x;
            my_next   = mag_y;
            mz_next   = mag_z;
            ax_next   = SUMSQ_W'(mag_x);
            ay_next   = SUMSQ_W'(mag_y);
            az_next   = SUMSQ_W'(mag_z);
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + (mx_reg[0] ? ax_reg : '0)
                               + (my_reg[0] ? ay_reg : '0)
                               + (mz_reg[0] ? az_reg : '0);
            mx_next   = mx_reg >> 1;
            my_next   = my_reg >> 1;
            mz_next   = mz_reg >> 1;
            ax_next   = ax_reg << 1;
            ay_next   = ay_reg << 1;
            az_next   = az_reg << 1;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        mz_reg  <= mz_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

>>> hw/rtl/asd_isqrt.sv
// ----------------------------------------------------------------------------
// Shake detector square root
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module asd_isqrt import asd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SUMSQ_W-1:0] value,
    output logic               done,
    output logic [ROOT_W-1:0]  root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUMSQ_W-1:0]  val_reg, val_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;

    assign rem_sh = {rem_reg, val_reg[SUMSQ_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_reg, 2'b01});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            val_next = val_reg << 2;
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> hw/rtl/asd_div.sv
// ----------------------------------------------------------------------------
// Shake detector mean divider
// Restoring division by a fixed divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_div import asd_pkg::*; #(
    parameter int DIVISOR = 50
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [CALSUM_W-1:0] dividend,
    output logic                done,
    output logic [CALSUM_W-1:0] quotient
);

    localparam int DIV_W  = $clog2(DIVISOR + 1);
    localparam int STEP_W = $clog2(CALSUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CALSUM_W - 1);
    localparam logic [DIV_W:0]    DIV_K     = (DIV_W+1)'(DIVISOR);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CALSUM_W-1:0] num_reg, num_next;
    logic [CALSUM_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W:0]      rem_sh;

    assign rem_sh = {rem_reg, num_reg[CALSUM_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = dividend;
            quot_next = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            if (rem_sh >= DIV_K) begin
                rem_next  = DIV_W'(rem_sh - DIV_K);
                quot_next = {quot_reg[CALSUM_W-2:0], 1'b1};
            end else begin
                rem_next  = DIV_W'(rem_sh);
                quot_next = {quot_reg[CALSUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> hw/rtl/asd_checker.sv
// ----------------------------------------------------------------------------
// Shake detector port checker
// Port-level properties of the shake detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "accel_shake_detector_top_defines.svh"

module asd_checker import asd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `ASD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    `ASD_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second beat taken while a request is in flight")

    `ASD_ASSERT_SAME(a_shake_level, aclk, aresetn, m_tvalid && m_tdata[SHAKE_BIT], (m_tdata[SMOOTH_LSB +: ROOT_W] >= m_tdata[BASE_LSB +: ROOT_W]) && !m_tdata[DONE_BIT], "shake reported below base level or on a calibration beat")

    `ASD_ASSERT_SAME(a_reset_quiet, aclk, aresetn, $rose(aresetn), !m_tvalid, "result valid right after reset")

endmodule

bind accel_shake_detector_top asd_checker u_asd_checker (.*);
